// ===== src/assert_macros.svh =====
// Assertion helper macros for the TCP header parser RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted (active-low reset)
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tcph_pkg.sv =====
// Shared types and constants for the TCP header parser.
// No dependencies; imported by every module of the block.
package tcph_pkg;

    // Byte positions within the fixed header
    localparam logic [5:0] IDX_DST   = 6'd2;
    localparam logic [5:0] IDX_SEQ   = 6'd4;
    localparam logic [5:0] IDX_ACK   = 6'd8;
    localparam logic [5:0] IDX_OFF   = 6'd12;
    localparam logic [5:0] IDX_FLG   = 6'd13;
    localparam logic [5:0] FIXED_LEN = 6'd20;

    // Option kinds and lengths of interest
    localparam logic [7:0] OPT_EOL = 8'd0;
    localparam logic [7:0] OPT_NOP = 8'd1;
    localparam logic [7:0] OPT_MSS = 8'd2;
    localparam logic [7:0] MSS_LEN = 8'd4;
    localparam logic [7:0] MIN_LEN = 8'd2;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_TRUNC = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_KIND = 2'd0,
        PH_LEN  = 2'd1,
        PH_MSS  = 2'd2,
        PH_SKIP = 2'd3
    } opt_phase_t;

    // Per-byte control from the top level
    typedef struct packed {
        logic take;
        logic last;
    } step_t;

    // Control from header capture to the option walker
    typedef struct packed {
        logic walk;
        logic clear;
    } opt_ctl_t;

    // Outcome of one byte
    typedef struct packed {
        logic    emit;
        status_t status;
    } verdict_t;

    // Fixed header fields
    typedef struct packed {
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [5:0]  header_len;
        logic [6:0]  flag_bits;
        logic [15:0] window;
        logic [15:0] checksum_field;
        logic [15:0] urgent_ptr;
    } hdr_fields_t;

endpackage

// ===== src/tcph_hdr_capture.sv =====
// Fixed header capture, byte position tracking and result decision.
// Depends on tcph_pkg.
module tcph_hdr_capture (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tcph_pkg::step_t       step,
    input  logic [7:0]            data_byte,
    output tcph_pkg::hdr_fields_t fields_next,
    output tcph_pkg::verdict_t    verdict,
    output tcph_pkg::opt_ctl_t    opt_ctl
);
    import tcph_pkg::*;

    hdr_fields_t fields_reg;
    logic [5:0]  idx_reg;
    logic [5:0]  idx_next;
    logic        reported_reg;
    logic        active;
    logic        hit;
    status_t     status;

    // Field update for the byte at the current position
    always_comb begin
        fields_next = fields_reg;
        active      = step.take && !reported_reg;
        idx_next    = idx_reg + 6'd1;
        if (active) begin
            priority if (idx_reg < IDX_DST) begin
                fields_next.src_port = {fields_reg.src_port[7:0], data_byte};
            end else if (idx_reg < IDX_SEQ) begin
                fields_next.dst_port = {fields_reg.dst_port[7:0], data_byte};
            end else if (idx_reg < IDX_ACK) begin
                fields_next.seq_num = {fields_reg.seq_num[23:0], data_byte};
            end else if (idx_reg < IDX_OFF) begin
                fields_next.ack_num = {fields_reg.ack_num[23:0], data_byte};
            end else if (idx_reg == IDX_OFF) begin
                fields_next.header_len = {data_byte[7:4], 2'b00};
            end else if (idx_reg == IDX_FLG) begin
                fields_next.flag_bits = data_byte[6:0];
            end else if (idx_reg < FIXED_LEN) begin
                {fields_next.window, fields_next.checksum_field, fields_next.urgent_ptr} =
                    {fields_reg.window[7:0], fields_reg.checksum_field,
                     fields_reg.urgent_ptr, data_byte};
            end else begin
                // option bytes are handled by the walker
            end
        end
    end

    // Decide whether this byte produces the segment's result
    always_comb begin
        hit    = 1'b0;
        status = STATUS_OK;
        priority if (idx_next >= FIXED_LEN && fields_next.header_len < FIXED_LEN) begin
            hit    = 1'b1;
            status = STATUS_SHORT;
        end else if (idx_next >= FIXED_LEN && idx_next >= fields_next.header_len) begin
            hit    = 1'b1;
            status = STATUS_OK;
        end else if (step.last) begin
            hit    = 1'b1;
            status = (idx_next < FIXED_LEN) ? STATUS_SHORT : STATUS_TRUNC;
        end else begin
            hit    = 1'b0;
        end
        verdict.emit   = active && hit;
        verdict.status = status;
        opt_ctl.walk   = active && (idx_reg >= FIXED_LEN);
        opt_ctl.clear  = step.take && step.last;
    end

    // Header state; the marked last byte rearms everything
    always_ff @(posedge aclk) begin
        if (!aresetn || opt_ctl.clear) begin
            fields_reg   <= '0;
            idx_reg      <= '0;
            reported_reg <= 1'b0;
        end else if (active) begin
            fields_reg   <= fields_next;
            idx_reg      <= idx_next;
            reported_reg <= verdict.emit;
        end
    end

endmodule

// ===== src/tcph_opt_walker.sv =====
// TCP option walker: steps through option bytes and records the MSS value.
// Depends on tcph_pkg.
module tcph_opt_walker (
    input  logic               aclk,
    input  logic               aresetn,
    input  tcph_pkg::opt_ctl_t opt_ctl,
    input  logic [7:0]         data_byte,
    output logic [15:0]        mss_next
);
    import tcph_pkg::*;

    opt_phase_t phase_reg, phase_next;
    logic [7:0] kind_reg, kind_next;
    logic [7:0] skip_reg, skip_next;
    logic [7:0] hi_reg, hi_next;
    logic       stopped_reg, stopped_next;
    logic [15:0] mss_reg;
    logic [7:0] len_less2;

    // One option byte per transfer
    always_comb begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        skip_next    = skip_reg;
        hi_next      = hi_reg;
        stopped_next = stopped_reg;
        mss_next     = mss_reg;
        // length below two counts as two
        len_less2    = (data_byte < MIN_LEN) ? 8'd0 : (data_byte - MIN_LEN);
        if (opt_ctl.walk && !stopped_reg) begin
            unique case (phase_reg)
                PH_KIND: begin
                    if (data_byte == OPT_EOL) begin
                        stopped_next = 1'b1;
                    end else if (data_byte != OPT_NOP) begin
                        kind_next  = data_byte;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (kind_reg == OPT_MSS && data_byte == MSS_LEN) begin
                        skip_next  = 8'd2;
                        phase_next = PH_MSS;
                    end else begin
                        skip_next  = len_less2;
                        phase_next = (len_less2 == 8'd0) ? PH_KIND : PH_SKIP;
                    end
                end
                PH_MSS: begin
                    if (skip_reg == 8'd2) begin
                        hi_next   = data_byte;
                        skip_next = 8'd1;
                    end else begin
                        mss_next   = {hi_reg, data_byte};
                        skip_next  = 8'd0;
                        phase_next = PH_KIND;
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_reg - 8'd1;
                    if (skip_next == 8'd0) begin
                        phase_next = PH_KIND;
                    end
                end
                default: begin
                    phase_next = PH_KIND;
                end
            endcase
        end
    end

    // Walker state; cleared at reset and at the end of each segment
    always_ff @(posedge aclk) begin
        if (!aresetn || opt_ctl.clear) begin
            phase_reg   <= PH_KIND;
            kind_reg    <= '0;
            skip_reg    <= '0;
            hi_reg      <= '0;
            stopped_reg <= 1'b0;
            mss_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            skip_reg    <= skip_next;
            hi_reg      <= hi_next;
            stopped_reg <= stopped_next;
            mss_reg     <= mss_next;
        end
    end

endmodule

// ===== src/tcp_header_parser.sv =====
// Top level of the TCP header parser: byte stream in, one header record out.
// Depends on tcph_pkg, tcph_hdr_capture, tcph_opt_walker, assert_macros.svh.
//
// Usage:
//   s_ channel: one segment byte per transfer in s_tdata, s_tlast on the
//   segment's final byte. m_ channel: one record per segment, fields in
//   m_tdata, status in m_tuser (ok, header short or bad offset, options cut).
//   A record is produced when the header (data offset * 4 bytes) is
//   complete, or when the segment ends first. Later bytes of the segment
//   are consumed and dropped; the byte with s_tlast rearms the parser.
//   The record is on m_tvalid in the cycle after the byte that completes
//   it is accepted. Throughput: one byte per cycle while no record stalls,
//   set by the single per-byte update of the position counter and field
//   registers. The result register is the only buffer: while a record waits
//   with m_tready low, s_tready drops and input stalls; a record taken in the
//   same cycle frees the register for the next one.
//   Reset (aresetn low, synchronous) empties the result register and
//   returns the parser to the first header byte.
module tcp_header_parser (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // [7:0] data_byte
    input  logic           s_tlast,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [175:0]   m_tdata,   // src_port, dst_port, seq_num, ack_num, header_len,
                                      // flag_bits, window, checksum_field, urgent_ptr,
                                      // mss_value, zero pad
    output logic [1:0]     m_tuser    // [1:0] status
);
    import tcph_pkg::*;

    `include "assert_macros.svh"

    step_t       step;
    hdr_fields_t fields_next;
    verdict_t    verdict;
    opt_ctl_t    opt_ctl;
    logic [15:0] mss_next;

    hdr_fields_t out_fields_reg;
    logic [15:0] out_mss_reg;
    status_t     out_status_reg;
    logic        out_valid_reg;

    // Input transfer; step packs take above last
    assign s_tready = !out_valid_reg || m_tready;
    assign step     = {s_tvalid && s_tready, s_tlast};

    tcph_hdr_capture u_hdr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .data_byte   (s_tdata),
        .fields_next (fields_next),
        .verdict     (verdict),
        .opt_ctl     (opt_ctl)
    );

    tcph_opt_walker u_opt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .opt_ctl   (opt_ctl),
        .data_byte (s_tdata),
        .mss_next  (mss_next)
    );

    // Result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (verdict.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; MSS only reported with a good header
    always_ff @(posedge aclk) begin
        if (verdict.emit) begin
            out_fields_reg <= fields_next;
            out_mss_reg    <= (verdict.status == STATUS_OK) ? mss_next : 16'd0;
            out_status_reg <= verdict.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000,
                       out_mss_reg,
                       out_fields_reg.urgent_ptr,
                       out_fields_reg.checksum_field,
                       out_fields_reg.window,
                       out_fields_reg.flag_bits,
                       out_fields_reg.header_len,
                       out_fields_reg.ack_num,
                       out_fields_reg.seq_num,
                       out_fields_reg.dst_port,
                       out_fields_reg.src_port};

    // Checks
    `ASSERT_CLK(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `ASSERT_RST(a_stall_blocks, aclk, aresetn,
        (m_tvalid && !m_tready) |-> !s_tready, "input taken while result stalled")
    `ASSERT_RST(a_ok_len, aclk, aresetn,
        (m_tvalid && m_tuser == STATUS_OK) |-> (m_tdata[101:96] >= FIXED_LEN),
        "ok record with short header length")
    `ASSERT_RST(a_err_no_mss, aclk, aresetn,
        (m_tvalid && m_tuser != STATUS_OK) |-> (m_tdata[172:157] == 16'd0),
        "error record carries mss")

endmodule

// ===== bench/tcph_checker.sv =====
`timescale 1ns / 100ps
// Checker for the TCP header parser: watches both stream channels, predicts each record.
// Depends on tcph_pkg; instantiated beside the parser by tb_top.
module tcph_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [175:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           errors,
    output int           pending
);
    import tcph_pkg::*;

    typedef struct {
        hdr_fields_t hdr;
        logic [15:0] mss;
        status_t     status;
    } header_record_t;

    // Parser image
    logic [5:0]   pos;
    hdr_fields_t  cur;
    logic [47:0]  tail_bytes;   // window, checksum, urgent pointer shift chain
    logic [15:0]  mss_seen;
    opt_phase_t   phase;
    logic [7:0]   opt_kind;
    logic [7:0]   opt_skip;
    logic [7:0]   mss_hi;
    logic         walk_done;
    logic         record_sent;

    header_record_t expected_records[$];
    int n_err  = 0;
    int n_pend = 0;

    assign errors  = n_err;
    assign pending = n_pend;

    task automatic clear_parser();
        pos         = '0;
        cur         = '0;
        tail_bytes  = '0;
        mss_seen    = '0;
        phase       = PH_KIND;
        opt_kind    = '0;
        opt_skip    = '0;
        mss_hi      = '0;
        walk_done   = 1'b0;
        record_sent = 1'b0;
    endtask

    initial clear_parser();

    // One byte of the option area
    task automatic advance_option(input logic [7:0] b);
        logic [7:0] olen;
        if (walk_done) return;
        case (phase)
            PH_KIND: begin
                if (b == OPT_EOL) begin
                    walk_done = 1'b1;
                end else if (b != OPT_NOP) begin
                    opt_kind = b;
                    phase    = PH_LEN;
                end
            end
            PH_LEN: begin
                olen = (b < MIN_LEN) ? MIN_LEN : b;
                if (opt_kind == OPT_MSS && b == MSS_LEN) begin
                    opt_skip = 8'd2;
                    phase    = PH_MSS;
                end else begin
                    opt_skip = olen - MIN_LEN;
                    phase    = (opt_skip == 8'd0) ? PH_KIND : PH_SKIP;
                end
            end
            PH_MSS: begin
                if (opt_skip == 8'd2) begin
                    mss_hi   = b;
                    opt_skip = 8'd1;
                end else begin
                    mss_seen = {mss_hi, b};
                    opt_skip = 8'd0;
                    phase    = PH_KIND;
                end
            end
            default: begin
                opt_skip = opt_skip - 8'd1;
                if (opt_skip == 8'd0) phase = PH_KIND;
            end
        endcase
    endtask

    task automatic queue_record(input status_t st);
        header_record_t rec;
        rec.hdr                = cur;
        rec.hdr.window         = tail_bytes[47:32];
        rec.hdr.checksum_field = tail_bytes[31:16];
        rec.hdr.urgent_ptr     = tail_bytes[15:0];
        rec.mss                = (st == STATUS_OK) ? mss_seen : 16'd0;
        rec.status             = st;
        expected_records.push_back(rec);
        record_sent = 1'b1;
    endtask

    // Header capture for one accepted byte
    task automatic predict_byte(input logic [7:0] b, input logic is_last);
        int  nxt;
        bit  made;
        made = 1'b0;
        if (!record_sent) begin
            if (pos < IDX_DST)        cur.src_port = {cur.src_port[7:0], b};
            else if (pos < IDX_SEQ)   cur.dst_port = {cur.dst_port[7:0], b};
            else if (pos < IDX_ACK)   cur.seq_num  = {cur.seq_num[23:0], b};
            else if (pos < IDX_OFF)   cur.ack_num  = {cur.ack_num[23:0], b};
            else if (pos == IDX_OFF)  cur.header_len = {b[7:4], 2'b00};
            else if (pos == IDX_FLG)  cur.flag_bits  = b[6:0];
            else if (pos < FIXED_LEN) tail_bytes = {tail_bytes[39:0], b};
            else                      advance_option(b);
            nxt = int'(pos) + 1;
            pos = nxt[5:0];
            if (nxt >= int'(FIXED_LEN)) begin
                if (cur.header_len < FIXED_LEN) begin
                    queue_record(STATUS_SHORT);
                    made = 1'b1;
                end else if (nxt >= int'(cur.header_len)) begin
                    queue_record(STATUS_OK);
                    made = 1'b1;
                end
            end
            if (!made && is_last)
                queue_record((nxt < int'(FIXED_LEN)) ? STATUS_SHORT : STATUS_TRUNC);
        end
        if (is_last) clear_parser();
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            n_err++;
            if (n_err <= 40)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
        end
    endtask

    // Compare each record transfer, then fold in the byte transfer of the same edge
    always @(posedge aclk) begin
        header_record_t oldest;
        if (!aresetn) begin
            clear_parser();
            expected_records.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_records.size() == 0) begin
                    n_err++;
                    if (n_err <= 40)
                        $display("%0t: unexpected record, expected none, actual %h / %0h",
                                 $time, m_tdata, m_tuser);
                end else begin
                    oldest = expected_records.pop_front();
                    check_field("src_port",       32'(oldest.hdr.src_port),
                                32'(m_tdata[15:0]));
                    check_field("dst_port",       32'(oldest.hdr.dst_port),
                                32'(m_tdata[31:16]));
                    check_field("seq_num",        oldest.hdr.seq_num,        m_tdata[63:32]);
                    check_field("ack_num",        oldest.hdr.ack_num,        m_tdata[95:64]);
                    check_field("header_len",     32'(oldest.hdr.header_len),
                                32'(m_tdata[101:96]));
                    check_field("flag_bits",      32'(oldest.hdr.flag_bits),
                                32'(m_tdata[108:102]));
                    check_field("window",         32'(oldest.hdr.window),
                                32'(m_tdata[124:109]));
                    check_field("checksum_field", 32'(oldest.hdr.checksum_field),
                                32'(m_tdata[140:125]));
                    check_field("urgent_ptr",     32'(oldest.hdr.urgent_ptr),
                                32'(m_tdata[156:141]));
                    check_field("mss_value",      32'(oldest.mss),
                                32'(m_tdata[172:157]));
                    check_field("status",         32'(oldest.status),        32'(m_tuser));
                end
            end
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
        end
        n_pend = expected_records.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the TCP header parser bench: clock, reset, segment stimulus and verdict.
// Depends on tcph_pkg, tcp_header_parser and tcph_checker.
module tb_top;
    import tcph_pkg::*;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'd0;   // [7:0] data_byte
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;           // src_port, dst_port, seq_num, ack_num, header_len,
                                     // flag_bits, window, checksum_field, urgent_ptr,
                                     // mss_value, zero pad
    logic [1:0]   m_tuser;           // [1:0] status
    int           errors;
    int           pending;

    logic [7:0] seg[$];
    int         bytes_sent    = 0;
    bit         hold_off_req  = 1'b0;
    bit         hold_off_done = 1'b0;

    tcp_header_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tcph_checker i_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Receiver: random ready runs and stalls, plus one long hold-off on request
    initial begin
        int g;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_off_done = 1'b1;
            end
            m_tready <= 1'b1;
            g = ($urandom_range(0, 9) == 0) ? 150 : gap_len() + 1;
            repeat (g) @(posedge aclk);
            g = gap_len();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    // One byte transfer, with an optional idle gap in front
    task automatic send_byte(input logic [7:0] b, input logic is_last, input int g);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_segment(input bit no_gaps);
        for (int i = 0; i < seg.size(); i++) begin
            send_byte(seg[i], i == seg.size() - 1, no_gaps ? 0 : gap_len());
            bytes_sent++;
        end
    endtask

    // Random segment: mostly a sound header with an option list, some of them damaged
    task automatic build_segment();
        int         offset;
        int         hl;
        int         r;
        int         olen;
        logic [7:0] bad_len[7];
        bad_len = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd6, 8'd8};
        seg.delete();
        repeat (20) seg.push_back(8'($urandom));
        offset = ($urandom_range(0, 1) == 0) ? $urandom_range(5, 8) : $urandom_range(9, 15);
        seg[12] = {4'(offset), 4'($urandom)};
        hl = offset * 4;
        while (seg.size() < hl) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                seg.push_back(OPT_NOP);
            end else if (r < 50) begin
                seg.push_back(OPT_MSS);
                seg.push_back(MSS_LEN);
                seg.push_back(8'($urandom));
                seg.push_back(8'($urandom));
            end else if (r < 55) begin
                seg.push_back(OPT_EOL);
            end else if (r < 70) begin
                seg.push_back(OPT_MSS);
                olen = int'(bad_len[$urandom_range(0, 6)]);
                seg.push_back(8'(olen));
                repeat ((olen < 2) ? 0 : olen - 2) seg.push_back(8'($urandom));
            end else begin
                seg.push_back(8'($urandom_range(3, 255)));
                olen = $urandom_range(0, 10);
                seg.push_back(8'(olen));
                repeat ((olen < 2) ? 0 : olen - 2) seg.push_back(8'($urandom));
            end
        end
        while (seg.size() > hl) void'(seg.pop_back());
        if ($urandom_range(0, 2) != 0)
            repeat ($urandom_range(1, 6)) seg.push_back(8'($urandom));
        // Damage: cut short, offset below five, or plain noise
        r = $urandom_range(0, 99);
        if (r < 15) begin
            olen = $urandom_range(1, seg.size());
            while (seg.size() > olen) void'(seg.pop_back());
        end else if (r < 25) begin
            seg[12][7:4] = 4'($urandom_range(0, 4));
        end else if (r < 32) begin
            seg.delete();
            repeat ($urandom_range(1, 40)) seg.push_back(8'($urandom));
        end
    endtask

    // Stimulus and verdict
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Segment of one byte: header short
        seg = '{8'h00};
        send_segment(1'b1);
        // All-ones header, offset six, MSS option closing on the marked byte
        seg.delete();
        repeat (12) seg.push_back(8'hFF);
        seg.push_back(8'h6F);
        repeat (7) seg.push_back(8'hFF);
        seg.push_back(OPT_MSS);
        seg.push_back(MSS_LEN);
        seg.push_back(8'hFF);
        seg.push_back(8'hFF);
        send_segment(1'b0);

        while (bytes_sent < 1800) begin
            if (!hold_off_req && bytes_sent >= 900) begin
                // Receiver holds off while tiny segments keep coming
                hold_off_req = 1'b1;
                repeat (30) begin
                    seg.delete();
                    repeat ($urandom_range(1, 3)) seg.push_back(8'($urandom));
                    send_segment(1'b1);
                end
            end else begin
                build_segment();
                send_segment($urandom_range(0, 4) == 0);
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/tcph_pkg.sv
src/tcph_hdr_capture.sv
src/tcph_opt_walker.sv
src/tcp_header_parser.sv
bench/tcph_checker.sv
bench/tb_top.sv
